// ----- rtl/core/lrt_pkg.sv -----
package lrt_pkg;

    localparam int LRT_CAPACITY  = 16;
    localparam int LRT_KEY_WIDTH = 16;

    localparam logic [1:0] CMD_TOUCH  = 2'd0;
    localparam logic [1:0] CMD_VICTIM = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] key;
    } t_lrt_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] victim_key;
        logic [4:0]  occupancy;
    } t_lrt_rsp;

    typedef struct packed {
        logic search;
        logic pop;
        logic append;
    } t_lrt_cell_ctl;

endpackage

// ----- rtl/core/lrt_if.sv -----
interface lrt_req_if;
    import lrt_pkg::*;

    logic     valid;
    logic     ready;
    t_lrt_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lrt_rsp_if;
    import lrt_pkg::*;

    logic     valid;
    logic     ready;
    t_lrt_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/lrt_cell.sv -----
module lrt_cell #(
    parameter int KW = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lrt_pkg::t_lrt_cell_ctl i_ctl,
    input  logic [KW-1:0]          i_key,
    input  logic                   i_chain_sh,
    input  logic [KW-1:0]          i_up_key,
    input  logic                   i_up_valid,
    input  logic                   i_dn_valid_nxt,
    output logic                   o_chain_sh,
    output logic [KW-1:0]          o_key,
    output logic                   o_valid,
    output logic                   o_valid_nxt
);
    import lrt_pkg::*;

    logic [KW-1:0] r_key;
    logic          r_valid;
    logic [KW-1:0] n_key;
    logic          n_valid;
    logic          w_match;
    logic          w_sh;
    logic          w_vnxt;
    logic [KW-1:0] w_key_sh;
    logic          w_load;

    always_comb begin
        w_match  = i_ctl.search && r_valid && (r_key == i_key);
        w_sh     = i_chain_sh || w_match || i_ctl.pop;
        w_vnxt   = w_sh ? i_up_valid : r_valid;
        w_key_sh = w_sh ? i_up_key : r_key;
        // new key lands in the lowest slot left empty after the shift
        w_load   = i_ctl.append && !w_vnxt && i_dn_valid_nxt;
        n_valid  = w_vnxt || w_load;
        n_key    = w_load ? i_key : w_key_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_chain_sh  = w_sh;
    assign o_key       = r_key;
    assign o_valid     = r_valid;
    assign o_valid_nxt = w_vnxt;

endmodule

// ----- rtl/core/lru_replacement_tracker_top.sv -----
// Exact LRU recency list of up to CAPACITY distinct keys, held in a row of
// cells with the least recent key in cell 0. One command is taken per cycle and
// its result appears registered on the next cycle; a new request is accepted
// whenever the result register is empty or being taken. Each command is resolved
// combinationally: every cell compares the key at once, a shift enable ripples
// up the row from the matching cell, each cell shifted pulls its upper neighbor,
// and a touched key is written into the lowest cell left empty. The length of
// that ripple through CAPACITY cells sets the clock period. Keys wider than 16
// bits are not possible at the port, so cells hold at most 16 key bits.
module lru_replacement_tracker_top #(
    parameter int CAPACITY  = lrt_pkg::LRT_CAPACITY,
    parameter int KEY_WIDTH = lrt_pkg::LRT_KEY_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrt_req_if.sink   i_req,
    lrt_rsp_if.source o_rsp
);
    import lrt_pkg::*;

    localparam int KW = (KEY_WIDTH < 16) ? KEY_WIDTH : 16;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          w_fire;
    logic [KW-1:0] w_key;
    t_lrt_cell_ctl w_ctl;
    logic          w_hit;
    logic          w_full;
    logic          w_empty;

    logic [KW-1:0] w_cell_key  [CAPACITY];
    logic          w_cell_valid[CAPACITY];
    logic          w_cell_vnxt [CAPACITY];
    logic          w_sh        [CAPACITY+1];
    logic [CAPACITY-1:0] w_valid_vec;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_lrt_rsp      r_out;
    t_lrt_rsp      n_out;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_key       = KW'(i_req.payload.key);

    // a full row with no match leaves no empty cell, so the append drops itself
    always_comb begin
        w_ctl.search = w_fire && (i_req.payload.command == CMD_TOUCH ||
                                  i_req.payload.command == CMD_ERASE);
        w_ctl.pop    = w_fire && (i_req.payload.command == CMD_VICTIM);
        w_ctl.append = w_fire && (i_req.payload.command == CMD_TOUCH);
    end

    assign w_sh[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KW-1:0] w_up_key;
            logic          w_up_valid;
            logic          w_dn_vnxt;

            if (g == CAPACITY - 1) begin : g_top
                assign w_up_key   = '0;
                assign w_up_valid = 1'b0;
            end else begin : g_mid
                assign w_up_key   = w_cell_key[g+1];
                assign w_up_valid = w_cell_valid[g+1];
            end

            if (g == 0) begin : g_bot
                assign w_dn_vnxt = 1'b1;
            end else begin : g_up
                assign w_dn_vnxt = w_cell_vnxt[g-1];
            end

            lrt_cell #(
                .KW(KW)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (w_ctl),
                .i_key          (w_key),
                .i_chain_sh     (w_sh[g]),
                .i_up_key       (w_up_key),
                .i_up_valid     (w_up_valid),
                .i_dn_valid_nxt (w_dn_vnxt),
                .o_chain_sh     (w_sh[g+1]),
                .o_key          (w_cell_key[g]),
                .o_valid        (w_cell_valid[g]),
                .o_valid_nxt    (w_cell_vnxt[g])
            );

            assign w_valid_vec[g] = w_cell_valid[g];
        end
    endgenerate

    // with search on and pop off, the top of the chain is the any-match flag
    assign w_hit   = w_sh[CAPACITY];
    assign w_full  = w_cell_valid[CAPACITY-1];
    assign w_empty = !w_cell_valid[0];

    always_comb begin
        n_count          = r_count;
        n_out.status     = ST_DONE;
        n_out.victim_key = '0;
        case (i_req.payload.command)
            CMD_TOUCH: begin
                if (!w_hit) begin
                    if (w_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            CMD_VICTIM: begin
                if (w_empty) begin
                    n_out.status = ST_MISS;
                end else begin
                    n_out.victim_key = 16'(w_cell_key[0]);
                    n_count          = r_count - CW'(1);
                end
            end
            CMD_ERASE: begin
                if (w_hit) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_out.status = ST_MISS;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

`ifndef ASSERT_OFF
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("occupied cell count differs from entry count");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid_vec ^ (w_valid_vec >> 1)) && (w_valid_vec[0] || !w_full))
        else $error("occupied cells are not packed from cell zero");

    a_occ_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.occupancy == 5'(r_count))
        else $error("reported occupancy differs from entry count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> r_count == CW'(CAPACITY))
        else $error("full status while list not full");

    a_victim_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_req.payload.command == CMD_VICTIM && !w_empty)
            |=> r_count == $past(r_count) - CW'(1))
        else $error("victim did not shrink the list");
`endif

endmodule
